>>> src/thrust_map_rls_estimator_unit_defines.svh
// Assertion macros for the thrust map estimator
`ifndef THRUST_MAP_RLS_ESTIMATOR_UNIT_DEFINES_SVH
`define THRUST_MAP_RLS_ESTIMATOR_UNIT_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset
`define TM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an implication holds in the cycle after the antecedent
`define TM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/tmrls_pkg.sv
// Shared types and constants for the thrust map estimator
`timescale 1ns / 1ps
package tmrls_pkg;
  localparam logic [1:0] ACT_CMD    = 2'd0;
  localparam logic [1:0] ACT_MEAS   = 2'd1;
  localparam logic [1:0] ACT_REINIT = 2'd2;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_RHO    = 2'd1;
  localparam logic [1:0] REG_MINAGE = 2'd2;
  localparam logic [1:0] REG_MAXAGE = 2'd3;

  localparam logic [63:0] COV_INIT = 64'd1099511627776000000;
  localparam logic signed [15:0] THR_ONE = 16'sd16384;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_TDIV  = 17'b00000000000000010,
    ST_RD    = 17'b00000000000000100,
    ST_CHK   = 17'b00000000000001000,
    ST_M1    = 17'b00000000000010000,
    ST_M2    = 17'b00000000000100000,
    ST_M3    = 17'b00000000001000000,
    ST_M4    = 17'b00000000010000000,
    ST_D     = 17'b00000000100000000,
    ST_PDIV  = 17'b00000001000000000,
    ST_E1    = 17'b00000010000000000,
    ST_G1    = 17'b00000100000000000,
    ST_G2    = 17'b00001000000000000,
    ST_G3    = 17'b00010000000000000,
    ST_G4    = 17'b00100000000000000,
    ST_E2    = 17'b01000000000000000,
    ST_OUT   = 17'b10000000000000000
  } state_e;

  typedef struct packed {
    logic        start;
    logic [127:0] dividend;
    logic [63:0]  divisor;
  } div_req_t;
endpackage

>>> src/tmrls_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module tmrls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/tmrls_div.sv
// Restoring divider, one quotient bit per cycle, 128 by 64 to 64 bits
`timescale 1ns / 1ps
module tmrls_div
  import tmrls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [64:0]  rem_q, rem_d;
  logic [63:0]  lo_q, lo_d;
  logic [63:0]  quot_q, quot_d;
  logic [63:0]  dvs_q;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         sat_q, sat_d;
  logic         done_q, done_d;
  logic [64:0]  shifted;

  always_comb begin
    rem_d = rem_q;
    lo_d = lo_q;
    quot_d = quot_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    sat_d = sat_q;
    done_d = 1'b0;
    shifted = {rem_q[63:0], lo_q[63]};
    if (req_i.start) begin
      rem_d = {1'b0, req_i.dividend[127:64]};
      lo_d = req_i.dividend[63:0];
      quot_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
      sat_d = (req_i.dividend[127:64] >= req_i.divisor);
    end else if (busy_q) begin
      lo_d = {lo_q[62:0], 1'b0};
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q <= lo_d;
    quot_q <= quot_d;
    sat_q <= sat_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : quot_q;
endmodule

>>> src/thrust_map_rls_estimator_unit.sv
// Top level of the thrust map estimator
//  channel | signals                                   | dir
//  in      | in_valid_i/in_ready_o action timestamp accel | in
//  out     | out_valid_o/out_ready_i throttle updated gain cov | out
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i             | in
// Command: throttle from the 64-step divider, full scale when gain is zero.
// Measure: ST_CHK and ST_M1 per discarded word; ST_M2 to ST_E2 for an update.
// Reinit/no-op: RD then OUT. One word at a time; output register holds a result
// until taken. Reset clears pointers and estimate; the history RAM needs no clear.
`timescale 1ns / 1ps
`include "thrust_map_rls_estimator_unit_defines.svh"
module thrust_map_rls_estimator_unit
  import tmrls_pkg::*;
#(
  parameter int HistoryDepth = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [31:0]        timestamp_us_i,
  input  logic signed [21:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] throttle_o,
  output logic               updated_o,
  output logic signed [31:0] gain_o,
  output logic [63:0]        covariance_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  localparam int AW = $clog2(HistoryDepth);
  localparam int CW = $clog2(HistoryDepth + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HistoryDepth);

  state_e state_q, state_d;
  logic [30:0] init_gain_q;
  logic [16:0] rho_q;
  logic [19:0] min_age_q, max_age_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic signed [31:0] gain_q, gain_d;
  logic [63:0] cov_q, cov_d;
  logic [1:0] act_q;
  logic [31:0] now_q;
  logic signed [21:0] accel_q;
  logic signed [15:0] thr_q, thr_d;
  logic signed [15:0] res_thr_q, res_thr_d;
  logic upd_q, upd_d;
  logic neg_q, neg_d;
  logic [63:0] t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic [127:0] acc_q, acc_d;
  logic out_valid_q, out_valid_d;
  logic signed [15:0] o_thr_q;
  logic o_upd_q;
  div_req_t dreq;
  logic ddone;
  logic [63:0] dquot;

  logic we;
  logic [AW-1:0] waddr;
  logic [31:0] rtime;
  logic [15:0] rthr;

  tmrls_ram #(.Width(32), .Depth(HistoryDepth)) u_time (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(now_q), .raddr_i(head_q),
    .rdata_o(rtime));
  tmrls_ram #(.Width(16), .Depth(HistoryDepth)) u_thr (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(thr_d), .raddr_i(head_q),
    .rdata_o(rthr));
  tmrls_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  logic [31:0] age;
  logic [63:0] absacc, absgain, rho_eff;
  logic [64:0] dsum;
  logic signed [63:0] qs;
  logic signed [63:0] clampq;
  logic [AW:0] wsum;
  logic signed [35:0] gsum;
  logic signed [31:0] rthr_w;
  logic [16:0] abs_thr;
  logic [33:0] abs_e;

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    count_d = count_q;
    gain_d = gain_q;
    cov_d = cov_q;
    thr_d = thr_q;
    res_thr_d = res_thr_q;
    upd_d = upd_q;
    neg_d = neg_q;
    t0_d = t0_q;
    t1_d = t1_q;
    t2_d = t2_q;
    acc_d = acc_q;
    out_valid_d = out_valid_q;
    we = 1'b0;
    dreq = '0;
    age = now_q - rtime;
    rthr_w = 32'($signed(rthr));
    abs_thr = thr_q[15] ? 17'(-$signed(thr_q)) : 17'(thr_q);
    abs_e = t2_q[63] ? 34'(-$signed(t2_q)) : 34'(t2_q);
    absacc = accel_q[21] ? 64'(-$signed(64'(accel_q))) : 64'(accel_q);
    absgain = gain_q[31] ? 64'(-$signed(64'(gain_q))) : 64'(gain_q);
    rho_eff = (rho_q == '0) ? 64'd1 : 64'(rho_q);
    dsum = 65'(t0_q) + 65'(rho_eff << 24);
    qs = neg_q ? -$signed(dquot) : $signed(dquot);
    clampq = (dquot > 64'd16384) ? 64'sd16384 : qs;
    if (neg_q && dquot > 64'd16384) clampq = -64'sd16384;
    wsum = {1'b0, head_q} + (AW+1)'(count_q);
    waddr = (HistoryDepth & (HistoryDepth - 1)) == 0 ? wsum[AW-1:0] :
            ((wsum >= (AW+1)'(HistoryDepth)) ? AW'(wsum - (AW+1)'(HistoryDepth))
                                              : wsum[AW-1:0]);
    gsum = 36'(gain_q) + (neg_q ? -36'(t2_q) : 36'(t2_q));
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = ST_RD;
      end
      ST_RD: begin
        res_thr_d = '0;
        upd_d = 1'b0;
        case (act_q)
          ACT_CMD: begin
            if (gain_q == '0) begin
              thr_d = accel_q[21] ? -THR_ONE : THR_ONE;
              state_d = ST_E2;
            end else begin
              neg_d = accel_q[21] ^ gain_q[31];
              dreq.start = 1'b1;
              dreq.dividend = 128'(absacc << 14);
              dreq.divisor = absgain;
              state_d = ST_TDIV;
            end
          end
          ACT_MEAS: state_d = (count_q == '0) ? ST_OUT : ST_CHK;
          ACT_REINIT: begin
            gain_d = 32'(init_gain_q);
            cov_d = COV_INIT;
            state_d = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_TDIV: begin
        if (ddone) begin
          thr_d = 16'(clampq);
          state_d = ST_E2;
        end
      end
      ST_E2: begin
        if (act_q == ACT_CMD) begin
          we = 1'b1;
          res_thr_d = thr_d;
          if (count_q >= DEPTH_C) begin
            head_d = (head_q == AW'(HistoryDepth - 1)) ? '0 : head_q + AW'(1);
            waddr = head_q;
          end else begin
            count_d = count_q + CW'(1);
          end
          state_d = ST_OUT;
        end else begin
          cov_d = t1_q;
          gain_d = (gsum > 36'sd2147483647) ? 32'sh7fffffff :
                   (gsum < -36'sd2147483648) ? 32'sh80000000 : 32'(gsum);
          state_d = ST_OUT;
        end
      end
      ST_CHK: begin
        if (count_q == '0) begin
          state_d = ST_OUT;
        end else if (age > 32'(max_age_q)) begin
          head_d = (head_q == AW'(HistoryDepth - 1)) ? '0 : head_q + AW'(1);
          count_d = count_q - CW'(1);
          state_d = ST_M1;
        end else if (age < 32'(min_age_q)) begin
          state_d = ST_OUT;
        end else begin
          head_d = (head_q == AW'(HistoryDepth - 1)) ? '0 : head_q + AW'(1);
          count_d = count_q - CW'(1);
          thr_d = $signed(rthr);
          upd_d = 1'b1;
          t0_d = 64'(rthr_w * rthr_w);
          state_d = ST_M2;
        end
      end
      ST_M1: state_d = ST_CHK;
      ST_M2: begin
        acc_d = {64'd0, 64'(t0_q[31:0]) * 64'(cov_q[31:0])};
        t1_d = 64'(t0_q[31:0]) * 64'(cov_q[63:32]);
        state_d = ST_M3;
      end
      ST_M3: begin
        acc_d = acc_q + {32'd0, t1_q, 32'd0};
        state_d = ST_M4;
      end
      ST_M4: begin
        t0_d = (|acc_q[127:92]) ? '1 : acc_q[91:28];
        state_d = ST_D;
      end
      ST_D: begin
        dreq.start = 1'b1;
        dreq.dividend = {24'd0, cov_q, 40'd0};
        dreq.divisor = dsum[64] ? '1 : dsum[63:0];
        t0_d = 64'(48'(thr_q) * 48'(gain_q));
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        if (ddone) begin
          t1_d = dquot;
          state_d = ST_E1;
          t2_d = 64'($signed(64'(accel_q)) - ($signed(t0_q) / 64'sd16384));
        end
      end
      ST_E1: begin
        neg_d = thr_q[15] ^ t2_q[63];
        t0_d = 64'(abs_thr) * 64'(abs_e);
        state_d = ST_G1;
      end
      ST_G1: begin
        acc_d = {64'd0, 64'(t1_q[31:0]) * 64'(t0_q[31:0])};
        t2_d = 64'(t1_q[63:32]) * 64'(t0_q[31:0]);
        state_d = ST_G2;
      end
      ST_G2: begin
        acc_d = acc_q + {32'd0, t2_q, 32'd0};
        t2_d = 64'(t1_q[31:0]) * 64'(t0_q[63:32]);
        t0_d = 64'(t1_q[63:32]) * 64'(t0_q[63:32]);
        state_d = ST_G3;
      end
      ST_G3: begin
        acc_d = acc_q + {32'd0, t2_q, 32'd0} + {t0_q, 64'd0};
        state_d = ST_G4;
      end
      ST_G4: begin
        t2_d = (|acc_q[127:88]) ? 64'h200000000 :
               ((acc_q[117:54] > 64'h200000000) ? 64'h200000000 : acc_q[117:54]);
        state_d = ST_E2;
      end
      ST_OUT: begin
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_gain_q <= 31'd2143027;
      rho_q <= 17'd65405;
      min_age_q <= 20'd35000;
      max_age_q <= 20'd45000;
      head_q <= '0;
      count_q <= '0;
      gain_q <= 32'sd2143027;
      cov_q <= COV_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      count_q <= count_d;
      gain_q <= gain_d;
      cov_q <= cov_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN:   init_gain_q <= cfg_data_i;
          REG_RHO:    rho_q <= cfg_data_i[16:0];
          REG_MINAGE: min_age_q <= cfg_data_i[19:0];
          REG_MAXAGE: max_age_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      now_q <= timestamp_us_i;
      accel_q <= accel_z_i;
    end
    thr_q <= thr_d;
    res_thr_q <= res_thr_d;
    upd_q <= upd_d;
    neg_q <= neg_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    t2_q <= t2_d;
    acc_q <= acc_d;
    if (state_q == ST_OUT) begin
      o_thr_q <= res_thr_q;
      o_upd_q <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign throttle_o = o_thr_q;
  assign updated_o = o_upd_q;
  assign gain_o = gain_q;
  assign covariance_o = cov_q;

  `TM_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= DEPTH_C)
  `TM_ASSERT_IMPL(a_no_accept_busy, out_valid_q, !in_ready_o)
  `TM_ASSERT_NEXT(a_out_from_state, state_q == ST_OUT, out_valid_q)
endmodule
